// ===== hw/rtl/csm_pkg.sv =====
// Shared constants, types and helpers for the complex sparse matrix-vector unit.
package csm_pkg;

	localparam int VECTOR_DEPTH = 1024;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

	localparam int DATA_W   = 32;
	localparam int IDX_W    = 10;
	localparam int KIND_W   = 2;
	localparam int ACC_W    = 64;
	localparam int PROD_W   = 40;
	localparam int FRAC_W   = 24;
	localparam int ROWCNT_W = 11;
	localparam int TDATA_W  = 80;
	localparam int PAD_W    = TDATA_W - IDX_W - 2 * DATA_W;

	localparam logic [ROWCNT_W-1:0] MAX_ROWS = 11'd1024;
	localparam logic [IDX_W-1:0]    LAST_ROW_RESET = 10'd1023;

	// Word kinds on the input stream
	localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NONZERO = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

	// One classified word handed from the front to the back
	typedef struct packed {
		logic              empty_row;
		logic              eor;
		logic [DATA_W-1:0] a_re;
		logic [DATA_W-1:0] a_im;
		logic [DATA_W-1:0] x_re;
		logic [DATA_W-1:0] x_im;
	} q_item_t;

	// Queue fill status
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Saturate a 64-bit accumulator to signed 32 bits
	function automatic logic [DATA_W-1:0] sat32(input logic [ACC_W-1:0] v);
		logic [DATA_W-1:0] r;
		if ((v[ACC_W-1:DATA_W-1] == '0) || (v[ACC_W-1:DATA_W-1] == '1)) begin
			r = v[DATA_W-1:0];
		end else if (v[ACC_W-1]) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/csm_front.sv =====
// Front end: accepts input words, owns the x vector store, classifies words into the queue.
module csm_front #(
	parameter int VECTOR_DEPTH = csm_pkg::VECTOR_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [csm_pkg::KIND_W-1:0]   in_kind,
	input  logic [csm_pkg::IDX_W-1:0]    in_index,
	input  logic [csm_pkg::DATA_W-1:0]   in_re,
	input  logic [csm_pkg::DATA_W-1:0]   in_im,
	input  logic                         in_eor,
	input  csm_pkg::q_status_t           q_stat,
	output logic                         q_push,
	output csm_pkg::q_item_t             q_wdata
);

	localparam int AW    = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
	localparam int EXT_W = 17;

	logic [2*csm_pkg::DATA_W-1:0] mem [VECTOR_DEPTH];
	logic [2*csm_pkg::DATA_W-1:0] rdata_q;

	logic [EXT_W-1:0] idx_ext;
	logic [AW-1:0]    addr;
	logic             in_range;
	logic             accept;
	logic             is_write;
	logic             is_nz;
	logic             is_empty;

	logic                       valid_s1;
	logic                       empty_row_s1;
	logic                       eor_s1;
	logic                       in_range_s1;
	logic [csm_pkg::DATA_W-1:0] a_re_s1;
	logic [csm_pkg::DATA_W-1:0] a_im_s1;

	// Decode the incoming word
	assign idx_ext  = EXT_W'(in_index);
	assign addr     = idx_ext[AW-1:0];
	assign in_range = idx_ext < EXT_W'(VECTOR_DEPTH);
	assign accept   = in_valid && in_ready;

	always_comb begin
		is_write = 1'b0;
		is_nz    = 1'b0;
		is_empty = 1'b0;
		case (in_kind)
			csm_pkg::KIND_WRITE:   is_write = 1'b1;
			csm_pkg::KIND_NONZERO: is_nz    = 1'b1;
			csm_pkg::KIND_EMPTY:   is_empty = 1'b1;
			default: ;
		endcase
	end

	// Vector store: write x elements, read x for each nonzero
	always_ff @(posedge clk) begin
		if (accept && is_write && in_range) begin
			mem[addr] <= {in_im, in_re};
		end
		if (accept && is_nz) begin
			rdata_q <= mem[addr];
		end
	end

	// Hold a classified word until the queue takes it
	assign q_push   = valid_s1 && !q_stat.full;
	assign in_ready = !valid_s1 || !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= is_nz || is_empty;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			empty_row_s1 <= is_empty;
			eor_s1       <= in_eor;
			in_range_s1  <= in_range;
			a_re_s1      <= in_re;
			a_im_s1      <= in_im;
		end
	end

	// Drive the queue word; out-of-range columns read zero
	always_comb begin
		q_wdata.empty_row = empty_row_s1;
		q_wdata.eor       = eor_s1;
		q_wdata.a_re      = a_re_s1;
		q_wdata.a_im      = a_im_s1;
		q_wdata.x_re      = in_range_s1 ? rdata_q[csm_pkg::DATA_W-1:0] : '0;
		q_wdata.x_im      = in_range_s1 ? rdata_q[2*csm_pkg::DATA_W-1:csm_pkg::DATA_W] : '0;
	end

	a_stall_means_held: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && q_stat.full)
		else $error("front stalled without a held word");

endmodule

// ===== hw/rtl/csm_fifo.sv =====
// Short queue between the front and back ends.
module csm_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  csm_pkg::q_item_t   wdata,
	input  logic               pop,
	output csm_pkg::q_item_t   rdata,
	output csm_pkg::q_status_t stat
);

	localparam int QD = csm_pkg::QUEUE_DEPTH;
	localparam int QA = csm_pkg::QUEUE_AW;

	csm_pkg::q_item_t entry_q [QD];
	logic [QA-1:0]    wr_ptr_q;
	logic [QA-1:0]    rd_ptr_q;
	logic [QA:0]      count_q;

	assign stat.full  = count_q == (QA+1)'(QD);
	assign stat.empty = count_q == '0;
	assign rdata      = entry_q[rd_ptr_q];

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QA'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QA'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty queue");

endmodule

// ===== hw/rtl/csm_back.sv =====
// Back end: complex multiply, 64-bit accumulate, row emission with saturation.
module csm_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  csm_pkg::q_status_t           q_stat,
	input  csm_pkg::q_item_t             q_rdata,
	output logic                         q_pop,
	input  logic [csm_pkg::IDX_W-1:0]    last_row,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [csm_pkg::IDX_W-1:0]    out_row,
	output logic [csm_pkg::DATA_W-1:0]   out_re,
	output logic [csm_pkg::DATA_W-1:0]   out_im,
	output logic                         out_last
);

	localparam int AW = csm_pkg::ACC_W;
	localparam int PW = csm_pkg::PROD_W;
	localparam int FW = csm_pkg::FRAC_W;

	logic adv;

	logic signed [AW-1:0] m_rr;
	logic signed [AW-1:0] m_ii;
	logic signed [AW-1:0] m_ri;
	logic signed [AW-1:0] m_ir;

	logic          valid_s2;
	logic          empty_row_s2;
	logic          eor_s2;
	logic [PW-1:0] p_rr_s2;
	logic [PW-1:0] p_ii_s2;
	logic [PW-1:0] p_ri_s2;
	logic [PW-1:0] p_ir_s2;

	logic [AW-1:0] acc_re_q;
	logic [AW-1:0] acc_im_q;
	logic [AW-1:0] acc_re_nxt;
	logic [AW-1:0] acc_im_nxt;
	logic          emit;
	logic          is_last;

	logic [csm_pkg::IDX_W-1:0] row_cnt_q;

	// Move the whole back pipeline only when the output register is free
	assign adv   = !out_valid || out_ready;
	assign q_pop = adv && !q_stat.empty;

	// Stage 2: four partial products, floor-shifted to Q16.24
	assign m_rr = $signed(q_rdata.a_re) * $signed(q_rdata.x_re);
	assign m_ii = $signed(q_rdata.a_im) * $signed(q_rdata.x_im);
	assign m_ri = $signed(q_rdata.a_re) * $signed(q_rdata.x_im);
	assign m_ir = $signed(q_rdata.a_im) * $signed(q_rdata.x_re);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= !q_stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			empty_row_s2 <= q_rdata.empty_row;
			eor_s2       <= q_rdata.eor;
			p_rr_s2      <= m_rr[AW-1:FW];
			p_ii_s2      <= m_ii[AW-1:FW];
			p_ri_s2      <= m_ri[AW-1:FW];
			p_ir_s2      <= m_ir[AW-1:FW];
		end
	end

	// Stage 3: accumulate and decide whether the row ends here
	assign acc_re_nxt = acc_re_q + AW'($signed(p_rr_s2)) - AW'($signed(p_ii_s2));
	assign acc_im_nxt = acc_im_q + AW'($signed(p_ri_s2)) + AW'($signed(p_ir_s2));
	assign emit       = adv && valid_s2 && (empty_row_s2 || eor_s2);
	assign is_last    = row_cnt_q == last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q  <= '0;
			acc_im_q  <= '0;
			row_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (adv && valid_s2) begin
				if (empty_row_s2 || eor_s2) begin
					acc_re_q <= '0;
					acc_im_q <= '0;
				end else begin
					acc_re_q <= acc_re_nxt;
					acc_im_q <= acc_im_nxt;
				end
			end
			if (emit) begin
				row_cnt_q <= is_last ? '0 : row_cnt_q + 1'b1;
			end
			if (adv) begin
				out_valid <= emit;
			end
		end
	end

	// Output register: load the finished row word
	always_ff @(posedge clk) begin
		if (emit) begin
			out_row  <= row_cnt_q;
			out_last <= is_last;
			out_re   <= empty_row_s2 ? '0 : csm_pkg::sat32(acc_re_nxt);
			out_im   <= empty_row_s2 ? '0 : csm_pkg::sat32(acc_im_nxt);
		end
	end

	a_emit_clears_acc: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (acc_re_q == '0) && (acc_im_q == '0))
		else $error("accumulator not cleared after row end");

	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		emit && is_last |=> row_cnt_q == '0)
		else $error("row counter did not wrap after last row");

endmodule

// ===== hw/rtl/csr_sparse_matvec_unit.sv =====
// Top level: complex CSR sparse matrix times dense vector, y = A*x.
//
// Input stream (s_axis): one word per tvalid/tready handshake. tuser holds the
// kind: write an x element at index, a matrix nonzero at column index (tlast
// marks the last nonzero of its row), or an empty row. Other kinds are dropped.
// Output stream (m_axis): one word per finished row with the row number and
// the saturated Q8.24 complex sum; tlast marks the final row of the product,
// after which the row number wraps to 0.
// Configuration: cfg_wen writes cfg_wdata as the row count (0 acts as 1, above
// 1024 acts as 1024); write it only while the block is idle.
// Throughput: one input word per cycle unless m_axis stalls, set by the
// single-port x store and one complex multiply-accumulate per cycle in the
// back end. Path: a row-ending word passes the input stage, the queue, the
// multiply stage and the accumulate/output register before it shows on m_axis.
// Stall: the output register holds while m_axis_tready is low; the back end
// stops, the four-entry queue fills, then s_axis_tready drops.
// Reset: clears the accumulators, row counter, queue and valids and sets the
// row count to 1024; the x store is not cleared and must be written before use.
module csr_sparse_matvec_unit #(
	parameter int VECTOR_DEPTH = csm_pkg::VECTOR_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// tdata: index[9:0], value_re[41:10], value_im[73:42], zero pad
	input  logic [csm_pkg::TDATA_W-1:0]     s_axis_tdata,
	// tuser: kind[1:0]
	input  logic [csm_pkg::KIND_W-1:0]      s_axis_tuser,
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata: row[9:0], sum_re[41:10], sum_im[73:42], zero pad
	output logic [csm_pkg::TDATA_W-1:0]     m_axis_tdata,
	output logic                            m_axis_tlast,
	input  logic                            cfg_wen,
	input  logic [csm_pkg::ROWCNT_W-1:0]    cfg_wdata
);

	localparam int IW = csm_pkg::IDX_W;
	localparam int DW = csm_pkg::DATA_W;

	logic [IW-1:0]          last_row_q;
	logic [csm_pkg::ROWCNT_W-1:0] cfg_m1;

	csm_pkg::q_status_t q_stat;
	csm_pkg::q_item_t   q_wdata;
	csm_pkg::q_item_t   q_rdata;
	logic               q_push;
	logic               q_pop;

	logic [IW-1:0] out_row;
	logic [DW-1:0] out_re;
	logic [DW-1:0] out_im;

	// Hold the index of the final row, clamped to the legal row count
	assign cfg_m1 = cfg_wdata - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_row_q <= csm_pkg::LAST_ROW_RESET;
		end else if (cfg_wen) begin
			if (cfg_wdata == '0) begin
				last_row_q <= '0;
			end else if (cfg_wdata > csm_pkg::MAX_ROWS) begin
				last_row_q <= csm_pkg::LAST_ROW_RESET;
			end else begin
				last_row_q <= cfg_m1[IW-1:0];
			end
		end
	end

	csm_front #(
		.VECTOR_DEPTH(VECTOR_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser),
		.in_index (s_axis_tdata[IW-1:0]),
		.in_re    (s_axis_tdata[IW+DW-1:IW]),
		.in_im    (s_axis_tdata[IW+2*DW-1:IW+DW]),
		.in_eor   (s_axis_tlast),
		.q_stat   (q_stat),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	csm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	csm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.last_row  (last_row_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_row   (out_row),
		.out_re    (out_re),
		.out_im    (out_im),
		.out_last  (m_axis_tlast)
	);

	// Pack the result word
	assign m_axis_tdata = {{csm_pkg::PAD_W{1'b0}}, out_im, out_re, out_row};

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the complex CSR sparse matrix-vector unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import csm_pkg::*;

	localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int TARGET_WORDS   = 1100;

	localparam logic [DATA_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] Q_MIN     = 32'h8000_0000;
	localparam logic [DATA_W-1:0] Q_ONE     = 32'h0100_0000;
	localparam logic [DATA_W-1:0] Q_HALF    = 32'h0080_0000;
	localparam logic [DATA_W-1:0] Q_NEG_ONE = 32'hFF00_0000;
	localparam logic [DATA_W-1:0] Q_LSB     = 32'h0000_0001;

	typedef struct {
		logic [IDX_W-1:0]  row;
		logic [DATA_W-1:0] re;
		logic [DATA_W-1:0] im;
		logic              last;
	} row_sum_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [TDATA_W-1:0]  s_axis_tdata = '0;
	logic [KIND_W-1:0]   s_axis_tuser = '0;
	logic                s_axis_tlast = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]  m_axis_tdata;
	logic                m_axis_tlast;
	logic                cfg_wen = 1'b0;
	logic [ROWCNT_W-1:0] cfg_wdata = '0;

	// Mirror of the block state used to predict row sums
	logic [DATA_W-1:0]   x_re_mirror [VECTOR_DEPTH];
	logic [DATA_W-1:0]   x_im_mirror [VECTOR_DEPTH];
	logic [ACC_W-1:0]    acc_re_mirror = '0;
	logic [ACC_W-1:0]    acc_im_mirror = '0;
	logic [IDX_W-1:0]    row_mirror = '0;
	logic [ROWCNT_W-1:0] row_count_mirror = MAX_ROWS;

	row_sum_t pending_rows[$];
	int       written_cols[$];
	bit       col_written [VECTOR_DEPTH];

	int words_sent    = 0;
	int mismatches    = 0;
	int hold_requests = 0;
	bit tx_gaps_on    = 1'b1;
	bit rx_stalls_on  = 1'b1;

	csr_sparse_matvec_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Q8.24 times Q8.24, shifted back to Q.24 with rounding toward minus infinity
	function automatic longint q24_product(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
		longint p;
		p = longint'(signed'(a)) * longint'(signed'(b));
		return p >>> FRAC_W;
	endfunction

	// Clamp a 64-bit accumulator to the signed 32-bit range
	function automatic logic [DATA_W-1:0] clamp_q24(logic [ACC_W-1:0] acc);
		longint s;
		s = signed'(acc);
		if (s > 64'sd2147483647)
			return Q_MAX;
		if (s < -64'sd2147483648)
			return Q_MIN;
		return acc[DATA_W-1:0];
	endfunction

	// Emit the finished row, advance or wrap the row number, clear the sums
	function automatic void close_row(logic [DATA_W-1:0] s_re, logic [DATA_W-1:0] s_im);
		logic [ROWCNT_W-1:0] rows_eff;
		row_sum_t r;
		rows_eff = row_count_mirror;
		if (rows_eff == '0)
			rows_eff = 11'd1;
		else if (rows_eff > MAX_ROWS)
			rows_eff = MAX_ROWS;
		r.row  = row_mirror;
		r.re   = s_re;
		r.im   = s_im;
		r.last = ({1'b0, row_mirror} == rows_eff - 1'b1);
		pending_rows = {pending_rows, r};
		row_mirror    = r.last ? '0 : row_mirror + 1'b1;
		acc_re_mirror = '0;
		acc_im_mirror = '0;
	endfunction

	// Update the mirror for one accepted input word
	function automatic void predict_row_sum(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
			logic [DATA_W-1:0] v_re, logic [DATA_W-1:0] v_im, logic eor);
		logic [DATA_W-1:0] x_re;
		logic [DATA_W-1:0] x_im;
		case (kind)
		KIND_WRITE: begin
			x_re_mirror[idx] = v_re;
			x_im_mirror[idx] = v_im;
		end
		KIND_NONZERO: begin
			x_re = x_re_mirror[idx];
			x_im = x_im_mirror[idx];
			acc_re_mirror += ACC_W'(q24_product(v_re, x_re) - q24_product(v_im, x_im));
			acc_im_mirror += ACC_W'(q24_product(v_re, x_im) + q24_product(v_im, x_re));
			if (eor)
				close_row(clamp_q24(acc_re_mirror), clamp_q24(acc_im_mirror));
		end
		KIND_EMPTY: begin
			close_row('0, '0);
		end
		default: ;
		endcase
	endfunction

	// Idle length: mostly short, a few long
	function automatic int idle_len();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [DATA_W-1:0] rand_q24();
		logic [DATA_W-1:0] raw;
		int unsigned pick;
		raw  = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return {{6{raw[25]}}, raw[25:0]};
		if (pick < 75)
			return {{2{raw[29]}}, raw[29:0]};
		if (pick < 90)
			return raw;
		case ($urandom_range(0, 3))
		0: return Q_MAX;
		1: return Q_MIN;
		2: return '0;
		default: return '1;
		endcase
	endfunction

	// Column of an x entry that has been written
	function automatic logic [IDX_W-1:0] pick_col();
		return IDX_W'(written_cols[$urandom_range(0, written_cols.size() - 1)]);
	endfunction

	function automatic int row_len();
		if ($urandom_range(0, 9) < 7)
			return $urandom_range(1, 4);
		return $urandom_range(5, 12);
	endfunction

	// Next row count: in half the picks just past the current row so that last shows up
	function automatic logic [ROWCNT_W-1:0] pick_row_count();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		2: return MAX_ROWS;
		3: return ROWCNT_W'($urandom_range(1025, 2047));
		4: return 11'd1;
		default: return ROWCNT_W'(row_mirror) + ROWCNT_W'($urandom_range(1, 12));
		endcase
	endfunction

	// Offer one word, hold it until accepted, then maybe idle
	task automatic send_word(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] v_re, input logic [DATA_W-1:0] v_im, input logic eor);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tlast  <= eor;
		s_axis_tdata  <= {{PAD_W{1'b0}}, v_im, v_re, idx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_row_sum(kind, idx, v_re, v_im, eor);
		if (kind != KIND_RESERVED)
			words_sent++;
		if (kind == KIND_WRITE && !col_written[idx]) begin
			col_written[idx] = 1'b1;
			written_cols = {written_cols, int'(idx)};
		end
		gap = (tx_gaps_on && $urandom_range(0, 99) < 20) ? idle_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_row(input int nnz);
		for (int i = 0; i < nnz; i++)
			send_word(KIND_NONZERO, pick_col(), rand_q24(), rand_q24(), i == nnz - 1);
	endtask

	// Stop offering, wait for every expected row, then let the pipeline settle
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_row_count(input logic [ROWCNT_W-1:0] value);
		wait_drained();
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		row_count_mirror = value;
	endtask

	// Field extremes, rounding, saturation, dropped kinds and a discarded row
	task automatic test_directed_rows();
		send_word(KIND_WRITE, 10'd0, Q_MAX, Q_MIN, 1'b0);
		send_word(KIND_WRITE, 10'd1023, Q_MIN, Q_MAX, 1'b0);
		send_word(KIND_WRITE, 10'd1, Q_ONE, '0, 1'b0);
		send_word(KIND_WRITE, 10'd2, '0, Q_ONE, 1'b1);
		send_word(KIND_WRITE, 10'd3, 32'h0000_0003, 32'hFFFF_FFFD, 1'b0);
		send_word(KIND_NONZERO, 10'd1, Q_HALF, Q_NEG_ONE, 1'b1);
		send_word(KIND_NONZERO, 10'd0, Q_MAX, Q_MAX, 1'b1);
		send_word(KIND_NONZERO, 10'd1023, Q_MIN, Q_MIN, 1'b1);
		send_word(KIND_NONZERO, 10'd0, Q_MIN, '0, 1'b1);
		send_word(KIND_NONZERO, 10'd3, '1, Q_LSB, 1'b1);
		// pending nonzeros are thrown away by an empty row
		send_word(KIND_NONZERO, 10'd1, Q_MAX, Q_ONE, 1'b0);
		send_word(KIND_NONZERO, 10'd2, Q_ONE, Q_MIN, 1'b0);
		send_word(KIND_EMPTY, 10'd1023, Q_MAX, Q_MIN, 1'b1);
		send_word(KIND_RESERVED, 10'd1023, '1, '1, 1'b1);
		send_word(KIND_RESERVED, 10'd0, '0, '0, 1'b0);
		send_word(KIND_NONZERO, 10'd1, Q_ONE, Q_ONE, 1'b1);
		send_word(KIND_NONZERO, 10'd0, Q_HALF, Q_NEG_ONE, 1'b0);
		send_word(KIND_NONZERO, 10'd1023, Q_NEG_ONE, Q_HALF, 1'b0);
		send_word(KIND_NONZERO, 10'd2, Q_LSB, Q_MAX, 1'b1);
		send_word(KIND_EMPTY, '0, '0, '0, 1'b0);
	endtask

	// Row count at one, zero, all ones, just above the maximum and the maximum
	task automatic test_row_count_extremes();
		write_row_count(ROWCNT_W'(row_mirror) + 1'b1);
		send_word(KIND_EMPTY, '0, '0, '0, 1'b0);
		write_row_count(11'd1);
		send_row(2);
		send_word(KIND_EMPTY, '0, '0, '0, 1'b1);
		write_row_count('0);
		send_word(KIND_EMPTY, '0, '0, '0, 1'b0);
		write_row_count('1);
		send_row(1);
		write_row_count(MAX_ROWS + 1'b1);
		send_word(KIND_EMPTY, '0, '0, '0, 1'b0);
		write_row_count(MAX_ROWS);
	endtask

	// Hold the output for a long stretch while rows keep coming
	task automatic test_input_backpressure();
		tx_gaps_on = 1'b0;
		@(negedge clk);
		hold_requests++;
		@(posedge clk);
		repeat (12) send_row($urandom_range(1, 3));
		wait_drained();
		tx_gaps_on = 1'b1;
	endtask

	// Random products: mostly well-formed rows, plus noise and broken rows
	task automatic test_random_products();
		int action;
		repeat (48) send_word(KIND_WRITE, IDX_W'($urandom), rand_q24(), rand_q24(),
			1'($urandom));
		while (words_sent < TARGET_WORDS) begin
			write_row_count(pick_row_count());
			tx_gaps_on   = ($urandom_range(0, 3) != 0);
			rx_stalls_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(30, 90)) begin
				if (words_sent >= TARGET_WORDS)
					break;
				action = $urandom_range(0, 99);
				if (action < 10) begin
					send_word(KIND_WRITE, IDX_W'($urandom), rand_q24(), rand_q24(),
						1'($urandom));
				end else if (action < 14) begin
					send_word(KIND_RESERVED, IDX_W'($urandom), rand_q24(), rand_q24(),
						1'($urandom));
				end else if (action < 20) begin
					send_word(KIND_EMPTY, IDX_W'($urandom), rand_q24(), rand_q24(),
						1'($urandom));
				end else if (action < 25) begin
					repeat ($urandom_range(1, 3)) send_word(KIND_NONZERO, pick_col(),
						rand_q24(), rand_q24(), 1'b0);
				end else begin
					send_row(row_len());
				end
			end
		end
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
	endtask

	// Output ready: long hold on request, random stalls otherwise
	always @(posedge clk) begin
		static int hold_seen  = 0;
		static int hold_left  = 0;
		static int stall_left = 0;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (rx_stalls_on && $urandom_range(0, 99) < 15) begin
			stall_left = idle_len() - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Compare each accepted row word with the oldest expected row
	always @(posedge clk) begin
		row_sum_t want;
		logic [IDX_W-1:0]  got_row;
		logic [DATA_W-1:0] got_re;
		logic [DATA_W-1:0] got_im;
		if (m_axis_tvalid && m_axis_tready) begin
			got_row = m_axis_tdata[IDX_W-1:0];
			got_re  = m_axis_tdata[IDX_W +: DATA_W];
			got_im  = m_axis_tdata[IDX_W + DATA_W +: DATA_W];
			if (pending_rows.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word row=%0d sum=(%h,%h) last=%b",
					$time, got_row, got_re, got_im, m_axis_tlast);
			end else begin
				want = pending_rows.pop_front();
				if (got_row !== want.row || got_re !== want.re || got_im !== want.im ||
						m_axis_tlast !== want.last) begin
					mismatches++;
					$display("%0t: want row=%0d (%h,%h) last=%b, got row=%0d (%h,%h) last=%b",
						$time, want.row, want.re, want.im, want.last,
						got_row, got_re, got_im, m_axis_tlast);
				end
			end
		end
	end

	// Give up when no word moves on either side for too long
	always @(posedge clk) begin
		static int quiet_cycles = 0;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles, %0d rows outstanding",
					$time, quiet_cycles, pending_rows.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_rows();
		test_row_count_extremes();
		test_input_backpressure();
		test_random_products();
		wait_drained();
		if (mismatches == 0 && pending_rows.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/csm_pkg.sv
hw/rtl/csm_front.sv
hw/rtl/csm_fifo.sv
hw/rtl/csm_back.sv
hw/rtl/csr_sparse_matvec_unit.sv
bench/testbench.sv
